@@ src/cdq_pkg.sv @@
// Shared constants, types and helpers for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

    // Ring geometry and stored word width
    localparam int DEPTH  = 8;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Widths of the fields on the ports
    localparam int REQ_W   = 3;
    localparam int FIELD_W = 32;
    localparam int OCC_W   = 4;
    localparam int TDATA_W = ((3 * FIELD_W + 2 + OCC_W + 7) / 8) * 8;

    // Request codes; the unused codes behave as a status request
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STATUS     = 3'd4;

    typedef logic signed [DATA_W-1:0]  t_word;
    typedef logic signed [FIELD_W-1:0] t_field;

    // Controller to datapath
    typedef struct packed {
        logic latch;   // capture the incoming transaction
        logic exec;    // apply the request to indices, count and ring
        logic fill;    // refresh the end cache from the ring read data
        logic emit;    // load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // result register can take a new result this cycle
    } t_sts;

    // Keep the low DATA_W bits of a port value (sign-extend when wider)
    function automatic t_word to_word(input t_field v);
        return DATA_W'(v);
    endfunction

    // Sign-extend a stored word and fit it to a port field
    function automatic t_field to_field(input t_word w);
        return FIELD_W'(w);
    endfunction

endpackage

@@ src/cdq_ctrl.sv @@
// Request sequencer for the circular deque.
`timescale 1ns / 1ps

module cdq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cdq_pkg::t_sts  i_sts,
    output cdq_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                // hold here until the result register is free
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/cdq_datapath.sv @@
// Ring storage, indices, end cache and result register of the circular deque.
`timescale 1ns / 1ps

module cdq_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cdq_pkg::t_cmd                       i_cmd,
    output cdq_pkg::t_sts                       o_sts,
    input  logic [cdq_pkg::REQ_W-1:0]           i_req_type,
    input  cdq_pkg::t_field                     i_push_value,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_error,
    output cdq_pkg::t_field                     o_popped_value,
    output cdq_pkg::t_field                     o_front_value,
    output cdq_pkg::t_field                     o_back_value,
    output logic                                o_is_empty,
    output logic                                o_is_full,
    output logic [cdq_pkg::OCC_W-1:0]           o_occupancy
);

    localparam logic [cdq_pkg::IDX_W-1:0] IDX_LAST = cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1);
    localparam logic [cdq_pkg::CNT_W-1:0] CNT_FULL = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);

    // Ring memory with one write port and one registered read port
    cdq_pkg::t_word                 r_ring [cdq_pkg::DEPTH];
    cdq_pkg::t_word                 r_rd_data;

    // Captured transaction
    logic [cdq_pkg::REQ_W-1:0]      r_req;
    cdq_pkg::t_field                r_val;

    // Control state
    logic [cdq_pkg::IDX_W-1:0]      r_head;
    logic [cdq_pkg::IDX_W-1:0]      r_tail;
    logic [cdq_pkg::CNT_W-1:0]      r_count;
    logic                           r_fill_front;
    logic                           r_fill_back;
    logic                           r_out_valid;

    // Copies of the front and rear elements
    cdq_pkg::t_word                 r_front;
    cdq_pkg::t_word                 r_back;

    // Per-request result pieces
    logic                           r_err;
    cdq_pkg::t_field                r_popped;

    // Result register
    logic                           r_o_error;
    cdq_pkg::t_field                r_o_popped;
    cdq_pkg::t_field                r_o_front;
    cdq_pkg::t_field                r_o_back;
    logic                           r_o_empty;
    logic                           r_o_full;
    logic [cdq_pkg::OCC_W-1:0]      r_o_occ;

    // Next-state values for an executed request
    logic [cdq_pkg::IDX_W-1:0]      n_head;
    logic [cdq_pkg::IDX_W-1:0]      n_tail;
    logic [cdq_pkg::CNT_W-1:0]      n_count;
    logic                           n_fill_front;
    logic                           n_fill_back;
    cdq_pkg::t_word                 n_front;
    cdq_pkg::t_word                 n_back;
    logic                           n_err;
    cdq_pkg::t_field                n_popped;

    logic                           wr_en;
    logic [cdq_pkg::IDX_W-1:0]      wr_addr;
    logic [cdq_pkg::IDX_W-1:0]      rd_addr;
    logic [cdq_pkg::IDX_W-1:0]      head_inc;
    logic [cdq_pkg::IDX_W-1:0]      head_dec;
    logic [cdq_pkg::IDX_W-1:0]      tail_inc;
    logic [cdq_pkg::IDX_W-1:0]      tail_dec;
    cdq_pkg::t_word                 push_word;
    logic                           is_empty_now;
    logic                           is_full_now;

    assign head_inc     = (r_head == IDX_LAST) ? '0 : r_head + 1'b1;
    assign head_dec     = (r_head == '0) ? IDX_LAST : r_head - 1'b1;
    assign tail_inc     = (r_tail == IDX_LAST) ? '0 : r_tail + 1'b1;
    assign tail_dec     = (r_tail == '0) ? IDX_LAST : r_tail - 1'b1;
    assign push_word    = cdq_pkg::to_word(r_val);
    assign is_empty_now = (r_count == '0);
    assign is_full_now  = (r_count == CNT_FULL);

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_fill_front = 1'b0;
        n_fill_back  = 1'b0;
        n_front      = r_front;
        n_back       = r_back;
        n_err        = 1'b0;
        n_popped     = '0;
        wr_en        = 1'b0;
        wr_addr      = r_head;
        rd_addr      = head_inc;
        case (r_req)
            cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_REAR: begin
                if (is_full_now) begin
                    n_err = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    if (is_empty_now) begin
                        // first element always lands in slot zero
                        n_head  = '0;
                        n_tail  = '0;
                        wr_addr = '0;
                        n_front = push_word;
                        n_back  = push_word;
                    end else if (r_req == cdq_pkg::REQ_PUSH_FRONT) begin
                        n_head  = head_dec;
                        wr_addr = head_dec;
                        n_front = push_word;
                    end else begin
                        n_tail  = tail_inc;
                        wr_addr = tail_inc;
                        n_back  = push_word;
                    end
                end
            end
            cdq_pkg::REQ_POP_FRONT: begin
                if (is_empty_now) begin
                    n_err = 1'b1;
                end else begin
                    n_popped = cdq_pkg::to_field(r_front);
                    n_count  = r_count - 1'b1;
                    if (r_count != cdq_pkg::CNT_W'(1)) begin
                        n_head       = head_inc;
                        rd_addr      = head_inc;
                        n_fill_front = 1'b1;
                    end
                end
            end
            cdq_pkg::REQ_POP_REAR: begin
                if (is_empty_now) begin
                    n_err = 1'b1;
                end else begin
                    n_popped = cdq_pkg::to_field(r_back);
                    n_count  = r_count - 1'b1;
                    if (r_count != cdq_pkg::CNT_W'(1)) begin
                        n_tail      = tail_dec;
                        rd_addr     = tail_dec;
                        n_fill_back = 1'b1;
                    end
                end
            end
            default: begin
                // status request: nothing changes
            end
        endcase
    end

    // Ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_ring[wr_addr] <= push_word;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_fill_front <= 1'b0;
            r_fill_back  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_head       <= n_head;
                r_tail       <= n_tail;
                r_count      <= n_count;
                r_fill_front <= n_fill_front;
                r_fill_back  <= n_fill_back;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req_type;
            r_val <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_err    <= n_err;
            r_popped <= n_popped;
            r_front  <= n_front;
            r_back   <= n_back;
        end
        if (i_cmd.fill) begin
            if (r_fill_front) begin
                r_front <= r_rd_data;
            end
            if (r_fill_back) begin
                r_back <= r_rd_data;
            end
        end
        if (i_cmd.emit) begin
            r_o_error  <= r_err;
            r_o_popped <= r_popped;
            r_o_front  <= is_empty_now ? '0 : cdq_pkg::to_field(r_front);
            r_o_back   <= is_empty_now ? '0 : cdq_pkg::to_field(r_back);
            r_o_empty  <= is_empty_now;
            r_o_full   <= is_full_now;
            r_o_occ    <= cdq_pkg::OCC_W'(r_count);
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_error        = r_o_error;
    assign o_popped_value = r_o_popped;
    assign o_front_value  = r_o_front;
    assign o_back_value   = r_o_back;
    assign o_is_empty     = r_o_empty;
    assign o_is_full      = r_o_full;
    assign o_occupancy    = r_o_occ;

endmodule

@@ src/circular_deque.sv @@
// Top level of the circular deque: stream ports, sequencer and datapath.
`timescale 1ns / 1ps

// Double-ended queue of DEPTH signed words (8 x 32 bits) kept in a ring
// memory with head and tail indices and an element count. Each input
// transaction is one request: push front, push rear, pop front, pop rear,
// or status only (codes 5 to 7 act as status). Every request yields exactly
// one output transaction carrying an error flag (push when full, pop when
// empty), the popped value (zero unless a pop succeeded), the front and back
// values after the request (zero when empty), empty and full flags and the
// occupancy. One request is in flight at a time. The request is captured at
// its acceptance edge. The sequencer then executes it (index and count
// update, ring write and a registered read of the ring memory), then
// refreshes the cached front or back element from the read data; this step
// is taken for every request but only changes the cache after a pop. Last
// it loads the result register. A new request is accepted only once the
// previous one has passed the load step. The result register decouples the
// output side: the next request is accepted while an earlier result still
// waits, and a stalled output only holds the sequencer at the load step.
// There is no clearing pass after reset; ring slots are only read once
// written.
module circular_deque (
    input  logic         i_clk,
    input  logic         i_rst_n,

    // Request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] push_value
    input  logic [2:0]   s_axis_tuser,   // [2:0] req_type

    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [cdq_pkg::TDATA_W-1:0] m_axis_tdata,
        // [31:0] popped_value, [63:32] front_value, [95:64] back_value,
        // [96] is_empty, [97] is_full, [101:98] occupancy, rest zero
    output logic [0:0]   m_axis_tuser    // [0] error
);

    cdq_pkg::t_cmd                  cmd;
    cdq_pkg::t_sts                  sts;

    logic                           res_error;
    cdq_pkg::t_field                res_popped;
    cdq_pkg::t_field                res_front;
    cdq_pkg::t_field                res_back;
    logic                           res_empty;
    logic                           res_full;
    logic [cdq_pkg::OCC_W-1:0]      res_occ;

    // Sequencer: one request at a time through capture, execute, fill, emit
    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Ring, indices, front/back cache and the result register
    cdq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_type     (s_axis_tuser),
        .i_push_value   (s_axis_tdata),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_error        (res_error),
        .o_popped_value (res_popped),
        .o_front_value  (res_front),
        .o_back_value   (res_back),
        .o_is_empty     (res_empty),
        .o_is_full      (res_full),
        .o_occupancy    (res_occ)
    );

    // Pack the result transaction, lowest field first, zero padded
    assign m_axis_tdata = cdq_pkg::TDATA_W'({res_occ, res_full, res_empty,
                                             res_back, res_front, res_popped});
    assign m_axis_tuser = res_error;

`ifndef ASSERT_OFF
    // Empty flag agrees with the occupancy it travels with
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res_empty == (res_occ == '0)))
        else $error("empty flag disagrees with occupancy");

    // Full flag agrees with the occupancy it travels with
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res_full == (res_occ == cdq_pkg::OCC_W'(cdq_pkg::DEPTH))))
        else $error("full flag disagrees with occupancy");

    // An empty deque reports zero at both ends
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res_empty) |-> (res_front == '0 && res_back == '0))
        else $error("empty result carries non-zero end values");

    // Only one request in flight: no acceptance in the cycle after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in flight");
`endif

endmodule
